// ----- rtl/mspp_pkg.sv -----
// ----------------------------------------------------------------------------
// mspp_pkg: shared types and constants
// Stage register layouts, instruction codes and the beat layouts of the
// five-stage pipeline unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mspp_pkg;

    localparam int DMEM_BYTES_DEF = 1024;
    localparam int LANES          = 4;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 96;

    // action selector
    localparam logic [1:0] ACT_ADVANCE = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // opcodes and function field
    localparam logic [5:0] OP_RTYPE   = 6'd0;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] FUNCT_SUBU = 6'd35;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    typedef logic [2:0] kind_t;

    localparam kind_t K_NONE  = 3'd0;
    localparam kind_t K_ADD   = 3'd1;
    localparam kind_t K_SUB   = 3'd2;
    localparam kind_t K_LOAD  = 3'd3;
    localparam kind_t K_STORE = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] instr;
    } dec_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] imm;
        logic [4:0]  dst;
        kind_t       kind;
    } exe_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] res;
        logic [31:0] sdata;
        logic [4:0]  dst;
        kind_t       kind;
    } mem_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] data;
        logic [4:0]  dst;
        logic        we;
    } wbk_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] instr_word;
        logic [9:0]  mem_addr;
        logic [7:0]  mem_byte;
    } item_t;

    // first member is the top bit: packs with wb_valid at bit 0
    typedef struct packed {
        logic        drained;
        logic        fetch_stopped;
        logic [7:0]  read_byte;
        logic [31:0] store_word;
        logic [9:0]  store_addr;
        logic        store_valid;
        logic [31:0] wb_data;
        logic [4:0]  wb_reg;
        logic        wb_valid;
    } result_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ----- rtl/mspp_regfile.sv -----
// ----------------------------------------------------------------------------
// mspp_regfile: 32 x 32 register file
// One write port, two registered read ports. Per-entry valid bits give the
// all-zero reset; a same-edge write is bypassed into the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mspp_regfile
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mspp_pkg::rf_wr_t wr,
    input  wire logic            rd_en,
    input  wire logic [4:0]      rd_addr_a,
    input  wire logic [4:0]      rd_addr_b,
    output logic      [31:0]     rd_data_a,
    output logic      [31:0]     rd_data_b
);
    import mspp_pkg::*;

    logic [31:0] rf_mem [32];
    logic [31:0] valid_reg;
    logic [31:0] q_a_reg;
    logic [31:0] q_b_reg;
    logic [31:0] byp_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic        hit_a_reg;
    logic        hit_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rf_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q_a_reg <= rf_mem[rd_addr_a];
            q_b_reg <= rf_mem[rd_addr_b];
            byp_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_a_reg <= valid_reg[rd_addr_a];
                vld_b_reg <= valid_reg[rd_addr_b];
                hit_a_reg <= wr.en && (wr.addr == rd_addr_a);
                hit_b_reg <= wr.en && (wr.addr == rd_addr_b);
            end
        end
    end

    assign rd_data_a = hit_a_reg ? byp_reg : (vld_a_reg ? q_a_reg : '0);
    assign rd_data_b = hit_b_reg ? byp_reg : (vld_b_reg ? q_b_reg : '0);

endmodule

`default_nettype wire

// ----- rtl/mspp_dmem.sv -----
// ----------------------------------------------------------------------------
// mspp_dmem: byte-lane data memory
// Four byte banks, one write and one registered read per bank per cycle,
// so an unaligned word touches each bank once. Cleared row by row after
// reset; a same-edge write is bypassed into the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mspp_dmem #(
    parameter  int DMEM_BYTES = mspp_pkg::DMEM_BYTES_DEF,
    localparam int RW         = $clog2(DMEM_BYTES) - 2
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  rd_en,
    input  wire logic [mspp_pkg::LANES-1:0][RW-1:0]    rd_row,
    input  wire logic [mspp_pkg::LANES-1:0]            wr_en,
    input  wire logic [mspp_pkg::LANES-1:0][RW-1:0]    wr_row,
    input  wire logic [mspp_pkg::LANES-1:0][7:0]       wr_byte,
    output logic      [mspp_pkg::LANES-1:0][7:0]       rd_byte,
    output logic                                       busy
);
    import mspp_pkg::*;

    localparam int ROWS = DMEM_BYTES / LANES;

    logic                      busy_reg;
    logic [RW-1:0]             clr_row_reg;
    logic [LANES-1:0]          we_eff;
    logic [LANES-1:0][RW-1:0]  wrow_eff;
    logic [LANES-1:0][7:0]     wbyte_eff;

    always_comb
    begin
        if (busy_reg)
        begin
            we_eff    = '1;
            wrow_eff  = {LANES{clr_row_reg}};
            wbyte_eff = '0;
        end
        else
        begin
            we_eff    = wr_en;
            wrow_eff  = wr_row;
            wbyte_eff = wr_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_row_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == RW'(ROWS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        logic [7:0] bank_mem [ROWS];
        logic [7:0] q_reg;
        logic [7:0] byp_reg;
        logic       hit_reg;

        always_ff @(posedge clk)
        begin
            if (we_eff[g])
            begin
                bank_mem[wrow_eff[g]] <= wbyte_eff[g];
            end
            if (rd_en)
            begin
                q_reg   <= bank_mem[rd_row[g]];
                byp_reg <= wbyte_eff[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hit_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                hit_reg <= we_eff[g] && (wrow_eff[g] == rd_row[g]);
            end
        end

        assign rd_byte[g] = hit_reg ? byp_reg : q_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/mspp_stages.sv -----
// ----------------------------------------------------------------------------
// mspp_stages: pipeline stage registers and per-beat step logic
// Holds the decode, execute, memory and write back registers and the halt
// flag, advances them on an advance beat and forms the result of each beat.
// Also presents the read addresses the next beat will need.
// ----------------------------------------------------------------------------
`default_nettype none

module mspp_stages #(
    parameter  int DMEM_BYTES = mspp_pkg::DMEM_BYTES_DEF,
    localparam int AW         = $clog2(DMEM_BYTES),
    localparam int RW         = AW - 2
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                fire,
    input  wire mspp_pkg::item_t                     item,
    input  wire logic [31:0]                         rf_a,
    input  wire logic [31:0]                         rf_b,
    input  wire logic [mspp_pkg::LANES-1:0][7:0]     dm_byte,
    output mspp_pkg::rf_wr_t                         rf_wr,
    output logic      [4:0]                          rf_rd_a,
    output logic      [4:0]                          rf_rd_b,
    output logic      [mspp_pkg::LANES-1:0]          dm_we,
    output logic      [mspp_pkg::LANES-1:0][RW-1:0]  dm_wr_row,
    output logic      [mspp_pkg::LANES-1:0][7:0]     dm_wr_byte,
    output logic      [mspp_pkg::LANES-1:0][RW-1:0]  dm_ld_row,
    output mspp_pkg::result_t                        result
);
    import mspp_pkg::*;

    dec_t dec_reg, dec_next, nd;
    exe_t exe_reg, exe_next, ne;
    mem_t mem_reg, mem_next, nm;
    wbk_t wb_reg, wb_next, nw;
    logic halted_reg, halted_next, halted_adv;

    logic          adv;
    logic          byte_wr;
    logic          byte_rd;
    logic          wb_fire;
    logic          st_fire;
    logic [AW-1:0] m_addr;
    logic [1:0]    m_off;
    logic [RW-1:0] m_row;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] b_addr;
    logic [31:0]   ld_word;
    logic [31:0]   se_imm;
    logic [5:0]    op;
    logic [4:0]    rs;
    logic [4:0]    rt;
    logic [4:0]    rd;
    logic [31:0]   rs_val;
    logic [31:0]   rt_val;

    assign adv     = fire && (item.action == ACT_ADVANCE);
    assign byte_wr = fire && (item.action == ACT_WRITE);
    assign byte_rd = fire && (item.action == ACT_READ);
    assign b_addr  = AW'(item.mem_addr);

    // write back
    assign wb_fire = wb_reg.valid && wb_reg.we && (wb_reg.dst != 5'd0);
    assign rf_wr   = '{en: adv && wb_fire, addr: wb_reg.dst, data: wb_reg.data};

    // memory
    assign m_addr  = mem_reg.res[AW-1:0];
    assign m_off   = m_addr[1:0];
    assign m_row   = m_addr[AW-1:2];
    assign st_fire = mem_reg.valid && (mem_reg.kind == K_STORE);

    // big-endian: the byte at the word address is the most significant
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ld_word[8*(3-i) +: 8] = dm_byte[m_off + 2'(i)];
        end
    end

    always_comb
    begin
        nw = '0;
        if (mem_reg.valid)
        begin
            nw.valid = 1'b1;
            nw.dst   = mem_reg.dst;
            case (mem_reg.kind) inside
                K_LOAD:
                begin
                    nw.data = ld_word;
                    nw.we   = 1'b1;
                end
                K_ADD, K_SUB:
                begin
                    nw.data = mem_reg.res;
                    nw.we   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // execute
    assign se_imm = {{16{exe_reg.imm[15]}}, exe_reg.imm};

    always_comb
    begin
        nm = '0;
        if (exe_reg.valid)
        begin
            nm.valid = 1'b1;
            nm.dst   = exe_reg.dst;
            nm.kind  = exe_reg.kind;
            case (exe_reg.kind) inside
                K_LOAD, K_STORE:
                begin
                    nm.res   = exe_reg.a + se_imm;
                    nm.sdata = exe_reg.b;
                end
                K_ADD:   nm.res = exe_reg.a + exe_reg.b;
                K_SUB:   nm.res = exe_reg.a - exe_reg.b;
                default: ;
            endcase
        end
    end

    // decode: the write back of this beat lands before the register read
    assign op     = dec_reg.instr[31:26];
    assign rs     = dec_reg.instr[25:21];
    assign rt     = dec_reg.instr[20:16];
    assign rd     = dec_reg.instr[15:11];
    assign rs_val = (wb_fire && (wb_reg.dst == rs)) ? wb_reg.data : rf_a;
    assign rt_val = (wb_fire && (wb_reg.dst == rt)) ? wb_reg.data : rf_b;

    always_comb
    begin
        ne = '0;
        if (dec_reg.valid)
        begin
            ne.valid = 1'b1;
            ne.a     = rs_val;
            ne.b     = rt_val;
            ne.imm   = dec_reg.instr[15:0];
            unique case (op)
                OP_RTYPE:
                begin
                    ne.kind = (dec_reg.instr[5:0] == FUNCT_SUBU) ? K_SUB : K_ADD;
                    ne.dst  = rd;
                end
                OP_LW:
                begin
                    ne.kind = K_LOAD;
                    ne.dst  = rt;
                end
                OP_SW:   ne.kind = K_STORE;
                OP_BEQ:  ne.kind = K_NONE;
                default: ne.kind = K_NONE;
            endcase
        end
    end

    // fetch
    always_comb
    begin
        nd         = '0;
        halted_adv = halted_reg;
        if (!halted_reg)
        begin
            if (item.instr_word == HALT_WORD)
            begin
                halted_adv = 1'b1;
            end
            else
            begin
                nd.valid = 1'b1;
                nd.instr = item.instr_word;
            end
        end
    end

    always_comb
    begin
        if (adv)
        begin
            dec_next    = nd;
            exe_next    = ne;
            mem_next    = nm;
            wb_next     = nw;
            halted_next = halted_adv;
        end
        else
        begin
            dec_next    = dec_reg;
            exe_next    = exe_reg;
            mem_next    = mem_reg;
            wb_next     = wb_reg;
            halted_next = halted_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg    <= '0;
            exe_reg    <= '0;
            mem_reg    <= '0;
            wb_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            dec_reg    <= dec_next;
            exe_reg    <= exe_next;
            mem_reg    <= mem_next;
            wb_reg     <= wb_next;
            halted_reg <= halted_next;
        end
    end

    // addresses for the reads issued alongside the next accepted beat
    assign rf_rd_a = dec_next.instr[25:21];
    assign rf_rd_b = dec_next.instr[20:16];
    assign n_addr  = mem_next.res[AW-1:0];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dm_ld_row[l] = n_addr[AW-1:2] + RW'(2'(l) < n_addr[1:0]);
        end
    end

    // memory writes: a preload byte, or the four bytes of a store
    always_comb
    begin
        logic [1:0] idx;
        for (int l = 0; l < LANES; l++)
        begin
            idx = 2'(l) - m_off;
            if (byte_wr)
            begin
                dm_we[l]      = (b_addr[1:0] == 2'(l));
                dm_wr_row[l]  = b_addr[AW-1:2];
                dm_wr_byte[l] = item.mem_byte;
            end
            else
            begin
                dm_we[l]      = adv && st_fire;
                dm_wr_row[l]  = m_row + RW'(2'(l) < m_off);
                dm_wr_byte[l] = mem_reg.sdata[8*(3-idx) +: 8];
            end
        end
    end

    always_comb
    begin
        result               = '0;
        result.fetch_stopped = halted_next;
        result.drained       = halted_next && !dec_next.valid && !exe_next.valid
                               && !mem_next.valid && !wb_next.valid;
        if (adv && wb_fire)
        begin
            result.wb_valid = 1'b1;
            result.wb_reg   = wb_reg.dst;
            result.wb_data  = wb_reg.data;
        end
        if (adv && st_fire)
        begin
            result.store_valid = 1'b1;
            result.store_addr  = 10'(m_addr);
            result.store_word  = mem_reg.sdata;
        end
        if (byte_rd)
        begin
            result.read_byte = dm_byte[b_addr[1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/five_stage_mips_subset_pipeline_unit.sv -----
// Five-stage in-order pipeline (fetch, decode, execute, memory, write back)
// for addu, subu, lw and sw, with no forwarding and no hazard detection.
// Every beat gives exactly one result beat: an advance beat (action 0)
// clocks the pipeline once with the fetched word, action 1 writes and
// action 2 reads one data-memory byte. The unit sustains one beat per clock
// while m_axis_tready keeps up: a beat sits in the input register while the
// register file and the four byte banks of data memory deliver its
// operands, then its result is registered in the output register. A new
// beat is taken while a finished result still waits. After reset,
// s_axis_tready stays low while the data memory is cleared one row per
// cycle, DMEM_BYTES/4 rows (256 at the default). DMEM_BYTES must be a
// power of two; loads and stores are big-endian and wrap at the memory size.
// ----------------------------------------------------------------------------
// five_stage_mips_subset_pipeline_unit: top level
// Beat handshakes, input and result registers, register file, data memory
// and stage logic.
// ----------------------------------------------------------------------------
`default_nettype none

module five_stage_mips_subset_pipeline_unit #(
    parameter int DMEM_BYTES = mspp_pkg::DMEM_BYTES_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // instr_word[31:0], mem_addr[41:32], mem_byte[49:42], zero fill
    input  wire logic [mspp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // wb_valid[0], wb_reg[5:1], wb_data[37:6], store_valid[38],
    // store_addr[48:39], store_word[80:49], read_byte[88:81],
    // fetch_stopped[89], drained[90], zero fill
    output logic      [mspp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import mspp_pkg::*;

    localparam int AW = $clog2(DMEM_BYTES);
    localparam int RW = AW - 2;

    item_t                    in_item;
    item_t                    item_reg;
    logic                     item_valid_reg;
    result_t                  out_reg;
    logic                     out_valid_reg;
    result_t                  result;
    logic                     fire;
    logic                     accept;
    logic                     clr_busy;
    logic [AW-1:0]            in_addr;

    rf_wr_t                   rf_wr;
    logic [4:0]               rf_rd_a;
    logic [4:0]               rf_rd_b;
    logic [31:0]              rf_a;
    logic [31:0]              rf_b;

    logic [LANES-1:0]         dm_we;
    logic [LANES-1:0][RW-1:0] dm_wr_row;
    logic [LANES-1:0][7:0]    dm_wr_byte;
    logic [LANES-1:0][RW-1:0] dm_ld_row;
    logic [LANES-1:0][RW-1:0] dm_rd_row;
    logic [LANES-1:0][7:0]    dm_byte;

    assign in_item.action     = s_axis_tuser;
    assign in_item.instr_word = s_axis_tdata[31:0];
    assign in_item.mem_addr   = s_axis_tdata[41:32];
    assign in_item.mem_byte   = s_axis_tdata[49:42];
    assign in_addr            = AW'(in_item.mem_addr);

    assign fire          = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy && (!item_valid_reg || fire);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_reg);

    // a byte read fetches its row; otherwise fetch the word for a load
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dm_rd_row[l] = (s_axis_tuser == ACT_READ) ? in_addr[AW-1:2] : dm_ld_row[l];
        end
    end

    mspp_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rf_wr),
        .rd_en     (accept),
        .rd_addr_a (rf_rd_a),
        .rd_addr_b (rf_rd_b),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    mspp_dmem #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_dmem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_row  (dm_rd_row),
        .wr_en   (dm_we),
        .wr_row  (dm_wr_row),
        .wr_byte (dm_wr_byte),
        .rd_byte (dm_byte),
        .busy    (clr_busy)
    );

    mspp_stages #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_stages
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .rf_a       (rf_a),
        .rf_b       (rf_b),
        .dm_byte    (dm_byte),
        .rf_wr      (rf_wr),
        .rf_rd_a    (rf_rd_a),
        .rf_rd_b    (rf_rd_b),
        .dm_we      (dm_we),
        .dm_wr_row  (dm_wr_row),
        .dm_wr_byte (dm_wr_byte),
        .dm_ld_row  (dm_ld_row),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- rtl/mspp_checker.sv -----
// ----------------------------------------------------------------------------
// mspp_checker: port-level checks
// Watches the beats of the pipeline unit: result stability under stall,
// register zero never written, and the halt and drain status staying put.
// ----------------------------------------------------------------------------
`default_nettype none

module mspp_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [mspp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mspp_pkg::*;

    localparam int WB_VALID_BIT = 0;
    localparam int ST_VALID_BIT = 38;
    localparam int STOP_BIT     = 89;
    localparam int DRAIN_BIT    = 90;

    logic out_beat;
    logic in_beat;
    logic seen_stop_reg;
    logic seen_drain_reg;

    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign in_beat  = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_stop_reg  <= 1'b0;
            seen_drain_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            seen_stop_reg  <= seen_stop_reg || m_axis_tdata[STOP_BIT];
            seen_drain_reg <= seen_drain_reg || m_axis_tdata[DRAIN_BIT];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[WB_VALID_BIT] |-> m_axis_tdata[5:1] != 5'd0)
        else $error("write back to register zero reported");

    a_drain_needs_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[DRAIN_BIT] |-> m_axis_tdata[STOP_BIT])
        else $error("drained without fetch stopped");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_stop_reg |-> m_axis_tdata[STOP_BIT])
        else $error("fetch stop status dropped");

    a_quiet_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_drain_reg && !in_beat
        |-> m_axis_tdata[DRAIN_BIT] && !m_axis_tdata[WB_VALID_BIT]
            && !m_axis_tdata[ST_VALID_BIT])
        else $error("activity after the pipeline drained");

endmodule

bind five_stage_mips_subset_pipeline_unit mspp_checker u_mspp_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: five-stage MIPS subset pipeline unit
// Drives preload, dump and advance beats into the unit, tracks register file,
// data memory and the four stage latches in a scoreboard class, and compares
// every result beat field by field with the predicted outcome.
// ----------------------------------------------------------------------------

module testbench;

    import mspp_pkg::*;

    localparam int unsigned DMEM        = DMEM_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          RAND_BEATS  = 920;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [5:0] FUNCT_ADDU = 6'd33;

    typedef struct packed {
        logic        valid;
        logic [31:0] instr;
    } dec_slot_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] imm;
        logic [4:0]  dst;
        kind_t       kind;
    } ex_slot_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] res;
        logic [31:0] sdata;
        logic [4:0]  dst;
        kind_t       kind;
    } mem_slot_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] data;
        logic [4:0]  dst;
        logic        we;
    } wb_slot_t;

    class pipe_scoreboard;
        logic [31:0] gpr [32];
        logic [7:0]  dmem [DMEM];
        dec_slot_t   dec_q;
        ex_slot_t    ex_q;
        mem_slot_t   mem_q;
        wb_slot_t    wb_q;
        bit          halted;
        result_t     expected_beats [$];
        int          errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            dec_q  = '0;
            ex_q   = '0;
            mem_q  = '0;
            wb_q   = '0;
            halted = 1'b0;
            errors = 0;
        endfunction

        function int unsigned wrap_byte(logic [31:0] base, int unsigned off);
            return ((base % DMEM) + off) % DMEM;
        endfunction

        // big-endian: lowest address holds the top byte
        function logic [31:0] read_word(logic [31:0] base);
            logic [31:0] w;
            w = '0;
            for (int i = 0; i < 4; i++)
                w = {w[23:0], dmem[wrap_byte(base, i)]};
            return w;
        endfunction

        function void write_word(logic [31:0] base, logic [31:0] w);
            for (int i = 0; i < 4; i++)
                dmem[wrap_byte(base, i)] = w[31 - 8 * i -: 8];
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // one accepted input beat, one expected result beat
        function void log_accepted(logic [1:0] act, logic [31:0] word,
                                   logic [9:0] addr, logic [7:0] mbyte);
            result_t     r;
            dec_slot_t   nd;
            ex_slot_t    ne;
            mem_slot_t   nm;
            wb_slot_t    nw;
            logic [31:0] offset;
            logic [5:0]  op;
            r  = '0;
            nd = '0;
            ne = '0;
            nm = '0;
            nw = '0;
            if (act == ACT_WRITE)
                dmem[addr % DMEM] = mbyte;
            else if (act == ACT_READ)
                r.read_byte = dmem[addr % DMEM];
            else if (act == ACT_ADVANCE)
            begin
                if (wb_q.valid && wb_q.we && wb_q.dst != 5'd0)
                begin
                    gpr[wb_q.dst] = wb_q.data;
                    r.wb_valid    = 1'b1;
                    r.wb_reg      = wb_q.dst;
                    r.wb_data     = wb_q.data;
                end
                if (mem_q.valid)
                begin
                    nw.valid = 1'b1;
                    nw.dst   = mem_q.dst;
                    case (mem_q.kind)
                        K_LOAD:
                        begin
                            nw.data = read_word(mem_q.res);
                            nw.we   = 1'b1;
                        end
                        K_STORE:
                        begin
                            write_word(mem_q.res, mem_q.sdata);
                            r.store_valid = 1'b1;
                            r.store_addr  = 10'(wrap_byte(mem_q.res, 0));
                            r.store_word  = mem_q.sdata;
                        end
                        K_ADD, K_SUB:
                        begin
                            nw.data = mem_q.res;
                            nw.we   = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (ex_q.valid)
                begin
                    offset   = {{16{ex_q.imm[15]}}, ex_q.imm};
                    nm.valid = 1'b1;
                    nm.dst   = ex_q.dst;
                    nm.kind  = ex_q.kind;
                    case (ex_q.kind)
                        K_LOAD, K_STORE:
                        begin
                            nm.res   = ex_q.a + offset;
                            nm.sdata = ex_q.b;
                        end
                        K_ADD:   nm.res = ex_q.a + ex_q.b;
                        K_SUB:   nm.res = ex_q.a - ex_q.b;
                        default: ;
                    endcase
                end
                // decode sees this cycle's write back
                if (dec_q.valid)
                begin
                    op       = dec_q.instr[31:26];
                    ne.valid = 1'b1;
                    ne.a     = gpr[dec_q.instr[25:21]];
                    ne.b     = gpr[dec_q.instr[20:16]];
                    ne.imm   = dec_q.instr[15:0];
                    if (op == OP_RTYPE)
                    begin
                        ne.kind = (dec_q.instr[5:0] == FUNCT_SUBU) ? K_SUB : K_ADD;
                        ne.dst  = dec_q.instr[15:11];
                    end
                    else if (op == OP_LW)
                    begin
                        ne.kind = K_LOAD;
                        ne.dst  = dec_q.instr[20:16];
                    end
                    else if (op == OP_SW)
                        ne.kind = K_STORE;
                    else
                        ne.kind = K_NONE;   // beq and anything unknown
                end
                if (!halted)
                begin
                    if (word == HALT_WORD)
                        halted = 1'b1;
                    else
                    begin
                        nd.valid = 1'b1;
                        nd.instr = word;
                    end
                end
                dec_q = nd;
                ex_q  = ne;
                mem_q = nm;
                wb_q  = nw;
            end
            r.fetch_stopped = halted;
            r.drained = halted && !dec_q.valid && !ex_q.valid && !mem_q.valid
                        && !wb_q.valid;
            expected_beats.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(logic [OUT_TDATA_W-1:0] beat);
            result_t want;
            result_t got;
            if (expected_beats.size() == 0)
            begin
                $error("result beat %h with nothing expected", beat);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            got  = result_t'(beat[$bits(result_t)-1:0]);
            cmp("wb_valid",      want.wb_valid,      got.wb_valid);
            cmp("wb_reg",        want.wb_reg,        got.wb_reg);
            cmp("wb_data",       want.wb_data,       got.wb_data);
            cmp("store_valid",   want.store_valid,   got.store_valid);
            cmp("store_addr",    want.store_addr,    got.store_addr);
            cmp("store_word",    want.store_word,    got.store_word);
            cmp("read_byte",     want.read_byte,     got.read_byte);
            cmp("fetch_stopped", want.fetch_stopped, got.fetch_stopped);
            cmp("drained",       want.drained,       got.drained);
            cmp("zero_fill", '0, 32'(beat[OUT_TDATA_W-1:$bits(result_t)]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bit                     calm = 1'b0;
    int unsigned            cycle_count = 0;
    pipe_scoreboard         book = new();

    five_stage_mips_subset_pipeline_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);

    // input beat noted before output check, so ordering at an edge is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                book.log_accepted(s_axis_tuser, s_axis_tdata[31:0],
                                  s_axis_tdata[41:32], s_axis_tdata[49:42]);
            if (m_axis_tvalid && m_axis_tready)
                book.check_outcome(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** five_stage_mips_subset_pipeline_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs,
                                          logic [4:0] rt, logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // bias towards a few registers so that results get reused
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 7))
                                            : 5'($urandom);
    endfunction

    function automatic logic [9:0] pick_addr();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            return 10'($urandom_range(0, 63));
        else if (pick == 2)
            return 10'($urandom_range(DMEM - 64, DMEM - 1));
        return 10'($urandom);
    endfunction

    function automatic logic [31:0] random_instr();
        int unsigned pick;
        logic [31:0] w;
        logic [15:0] imm;
        pick = $urandom_range(0, 99);
        imm  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 63))
                                           : 16'($urandom);
        if (pick < 22)
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), FUNCT_ADDU);
        else if (pick < 40)
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), FUNCT_SUBU);
        else if (pick < 45)
            w = {OP_RTYPE, 20'($urandom), 6'($urandom)};
        else if (pick < 68)
            w = enc_i(OP_LW, pick_reg(), pick_reg(), imm);
        else if (pick < 85)
            w = enc_i(OP_SW, pick_reg(), pick_reg(), imm);
        else if (pick < 89)
            w = enc_i(OP_BEQ, pick_reg(), pick_reg(), 16'($urandom));
        else if (pick < 92)
            w = {6'($urandom), 26'($urandom)};
        else if (pick < 95)
            w = '0;
        else
            w = $urandom;
        if (w == HALT_WORD)
            w = '0;
        return w;
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic drive_beat(logic [1:0] act, logic [31:0] word,
                              logic [9:0] addr, logic [7:0] mbyte);
        if (!calm && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, mbyte, addr, word};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic advance(logic [31:0] word);
        drive_beat(ACT_ADVANCE, word, 10'($urandom), 8'($urandom));
    endtask

    task automatic poke(logic [9:0] addr, logic [7:0] mbyte);
        drive_beat(ACT_WRITE, $urandom, addr, mbyte);
    endtask

    task automatic peek(logic [9:0] addr);
        drive_beat(ACT_READ, $urandom, addr, 8'($urandom));
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: word at 0..3 plus the top byte for wraparound loads
        poke(10'd0, 8'hFF);
        poke(10'd1, 8'h12);
        poke(10'd2, 8'h34);
        poke(10'd3, 8'h00);
        poke(10'd1023, 8'h80);
        peek(10'd1023);
        peek(10'd0);
        drive_beat(ACT_NONE, HALT_WORD, 10'h3FF, 8'hFF);
        advance(enc_i(OP_LW, 5'd0, 5'd1, 16'd0));
        advance(enc_i(OP_LW, 5'd0, 5'd2, 16'hFFFF));   // wraps to the top byte
        advance('0);
        advance('0);
        advance(enc_r(5'd1, 5'd2, 5'd3, FUNCT_ADDU));
        advance(enc_r(5'd1, 5'd2, 5'd4, FUNCT_SUBU));
        advance(enc_r(5'd1, 5'd2, 5'd0, FUNCT_ADDU));  // register zero kept
        advance('0);
        advance(enc_i(OP_SW, 5'd0, 5'd3, 16'd4));
        advance(enc_i(OP_SW, 5'd1, 5'd4, 16'h8000));
        advance(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFF));
        advance({6'd2, 26'h3FF_FFFF});                 // unknown opcode
        advance(enc_r(5'd31, 5'd31, 5'd31, 6'h2A));    // odd funct acts as addu
        peek(10'd4);                                   // memory touched mid-flight
        advance('0);
        peek(10'd5);

        for (int n = 0; n < RAND_BEATS; n++)
        begin
            calm = (n >= 300 && n < 450);
            if (n == 600)
                wait_results();
            pick = $urandom_range(0, 99);
            if (pick < 76)
                advance(random_instr());
            else if (pick < 87)
                poke(pick_addr(), 8'($urandom));
            else if (pick < 96)
                peek(pick_addr());
            else
                drive_beat(ACT_NONE, $urandom, 10'($urandom), 8'($urandom));
        end
        calm = 1'b0;

        // halt, drain, then words that fetch must ignore and a final dump
        advance(HALT_WORD);
        for (int n = 0; n < 6; n++)
            advance((n == 2) ? HALT_WORD : random_instr());
        poke(10'd1023, 8'h00);
        for (int n = 0; n < 8; n++)
            peek((n < 4) ? 10'(n) : pick_addr());
        peek(10'd1023);

        wait_results();
        repeat (10) @(posedge clk);
        if (book.errors == 0)
            $display("** five_stage_mips_subset_pipeline_unit: PASSED **");
        else
            $display("** five_stage_mips_subset_pipeline_unit: FAILED **");
        $finish;
    end

endmodule
